// ----- hdl/bmf_pkg.sv -----
// Package for the biased matrix factorization SGD block.
// Holds sizes, operation codes, register indexes, the sequencer state type and fixed-point helpers.
package bmf_pkg;
	localparam int NumUsers = 1024;
	localparam int NumItems = 2048;
	localparam int MaxDim = 128;
	localparam int UW = $clog2(NumUsers);
	localparam int IW = $clog2(NumItems);
	localparam int KW = $clog2(MaxDim);
	localparam int DW = 8;

	localparam logic [2:0] OP_LOAD_UF = 3'd0;
	localparam logic [2:0] OP_LOAD_IF = 3'd1;
	localparam logic [2:0] OP_LOAD_UB = 3'd2;
	localparam logic [2:0] OP_LOAD_IB = 3'd3;
	localparam logic [2:0] OP_TRAIN = 3'd4;
	localparam logic [2:0] OP_PREDICT = 3'd5;

	localparam logic [1:0] REG_MEAN = 2'd0;
	localparam logic [1:0] REG_LRATE = 2'd1;
	localparam logic [1:0] REG_REG = 2'd2;
	localparam logic [1:0] REG_DIM = 2'd3;

	localparam logic signed [47:0] ONE_Q16 = 48'sd65536;
	localparam logic signed [47:0] FIVE_Q16 = 48'sd327680;

	typedef enum logic [3:0] {
		ST_IDLE, ST_BRD, ST_DOT, ST_DOT_ACC, ST_FIN, ST_OUT,
		ST_UB_A, ST_UB_B, ST_IB_A, ST_IB_B,
		ST_FRD, ST_U_A, ST_U_B, ST_I_G, ST_I_A, ST_I_B
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
		if (x > 50'sd2147483647) return 32'sh7fffffff;
		if (x < -50'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	// round half up of a Q32.32 product to Q16.16, unsaturated
	function automatic logic signed [47:0] rnd(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p + 64'sd32768;
		return t[63:16];
	endfunction
endpackage

// ----- hdl/biased_matrix_factorization_sgd.sv -----
// Biased matrix factorization SGD engine, Q16.16, state in four synchronous memories.
// The result beat is valid after BRD, a DOT and DOT_ACC pair per element, and FIN.
// Predict then ends via OUT, train updates biases and factors; loads and unknown codes stay in idle.
// One item at a time; a waiting result holds off the input. The single multiplier and the
// single read port of each factor memory set the per-element cost.
// Reset clears control and configuration; bias and factor memories stay undefined until loaded.
module biased_matrix_factorization_sgd import bmf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic [2:0] operation,
	input  logic [9:0] user_index,
	input  logic [10:0] item_index,
	input  logic [6:0] element_index,
	input  logic signed [31:0] load_value,
	input  logic [2:0] rating,
	output logic out_valid,
	input  logic out_stall,
	output logic [18:0] prediction,
	output logic signed [31:0] error
);
	logic [18:0] mean_q;
	logic [16:0] lrate_q, regf_q;
	logic [7:0] dim_q;
	state_t st_q, st_d;

	logic signed [31:0] ub_mem [NumUsers];
	logic signed [31:0] ib_mem [NumItems];
	logic signed [31:0] uf_mem [NumUsers*MaxDim];
	logic signed [31:0] if_mem [NumItems*MaxDim];

	logic [2:0] op_q;
	logic [UW-1:0] u_q;
	logic [IW-1:0] i_q;
	logic [2:0] r_q;
	logic [DW-1:0] k_q, n_q;
	logic signed [31:0] ub_rd_q, ib_rd_q, uf_rd_q, if_rd_q;
	logic signed [55:0] acc_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] err_q, g_q, t_q, x_q, unew_q, qold_q;
	logic ov_q;
	logic [18:0] pred_q;
	logic signed [31:0] errout_q;

	logic signed [31:0] ma, mb;
	logic signed [63:0] mp;
	logic wr_cfg;
	logic [KW-1:0] kk, kr;
	logic [UW-1:0] ub_ra;
	logic [IW-1:0] ib_ra;
	logic signed [31:0] mulsat;
	logic signed [55:0] accsum, clampv;

	function automatic logic signed [31:0] sat_of(input logic signed [63:0] p);
		logic signed [47:0] m;
		m = rnd(p);
		return sat32({{2{m[47]}}, m});
	endfunction

	function automatic logic signed [31:0] unew_calc(input logic signed [31:0] x,
		input logic signed [63:0] p);
		logic signed [47:0] m;
		logic signed [31:0] ms;
		m = rnd(p);
		ms = sat32({{2{m[47]}}, m});
		return sat32({{18{x[31]}}, x} + {{18{ms[31]}}, ms});
	endfunction

	assign pready = 1'b1;
	assign wr_cfg = psel && penable && pwrite;
	assign kk = k_q[KW-1:0];
	// bias reads follow the incoming beat while idle; factor reads run one element ahead at I_B
	assign ub_ra = (st_q == ST_IDLE) ? user_index : u_q;
	assign ib_ra = (st_q == ST_IDLE) ? item_index : i_q;
	assign kr = (st_q == ST_I_B) ? kk + 1'b1 : kk;
	assign in_stall = (st_q != ST_IDLE) || ov_q;
	assign out_valid = ov_q;
	assign prediction = pred_q;
	assign error = errout_q;

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_MEAN: prdata = {13'd0, mean_q};
			REG_LRATE: prdata = {15'd0, lrate_q};
			REG_REG: prdata = {15'd0, regf_q};
			REG_DIM: prdata = {24'd0, dim_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= 19'd229376;
			lrate_q <= 17'd852;
			regf_q <= 17'd66;
			dim_q <= 8'd100;
		end else if (wr_cfg) begin
			unique case (paddr[3:2])
				REG_MEAN: mean_q <= pwdata[18:0];
				REG_LRATE: lrate_q <= pwdata[16:0];
				REG_REG: regf_q <= pwdata[16:0];
				REG_DIM: dim_q <= pwdata[7:0];
			endcase
		end
	end

	// shared multiplier operands per state
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (st_q)
			ST_DOT: begin ma = uf_rd_q; mb = if_rd_q; end
			ST_UB_A: begin ma = {15'd0, regf_q}; mb = ub_rd_q; end
			ST_IB_A: begin ma = {15'd0, regf_q}; mb = ib_rd_q; end
			ST_UB_B, ST_IB_B, ST_U_B, ST_I_B: begin ma = {15'd0, lrate_q}; mb = t_q; end
			ST_FRD: begin ma = err_q; mb = if_rd_q; end
			ST_U_A, ST_I_A: begin ma = {15'd0, regf_q}; mb = x_q; end
			ST_I_G: begin ma = err_q; mb = unew_q; end
			default: ;
		endcase
	end
	assign mp = ma * mb;
	assign mulsat = sat_of(mp);
	assign accsum = acc_q + rnd(prod_q);
	always_comb begin
		clampv = acc_q;
		if (acc_q < ONE_Q16) clampv = ONE_Q16;
		if (acc_q > FIVE_Q16) clampv = FIVE_Q16;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (in_valid && !ov_q && (operation == OP_TRAIN || operation == OP_PREDICT))
				st_d = ST_BRD;
			ST_BRD: st_d = (n_q == 0) ? ST_FIN : ST_DOT;
			ST_DOT: st_d = ST_DOT_ACC;
			ST_DOT_ACC: st_d = (k_q == n_q) ? ST_FIN : ST_DOT;
			ST_FIN: st_d = ST_OUT;
			ST_OUT: st_d = (op_q == OP_TRAIN) ? ST_UB_A : ST_IDLE;
			ST_UB_A: st_d = ST_UB_B;
			ST_UB_B: st_d = ST_IB_A;
			ST_IB_A: st_d = ST_IB_B;
			ST_IB_B: st_d = (n_q == 0) ? ST_IDLE : ST_FRD;
			ST_FRD: st_d = ST_U_A;
			ST_U_A: st_d = ST_U_B;
			ST_U_B: st_d = ST_I_G;
			ST_I_G: st_d = ST_I_A;
			ST_I_A: st_d = ST_I_B;
			ST_I_B: st_d = (k_q + 1'b1 == n_q) ? ST_IDLE : ST_FRD;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (ov_q && !out_stall) ov_q <= 1'b0;
			if (st_q == ST_FIN) ov_q <= 1'b1;
		end
	end

	// memories: synchronous read, one write port each
	always_ff @(posedge clk) begin
		ub_rd_q <= ub_mem[ub_ra];
		ib_rd_q <= ib_mem[ib_ra];
		uf_rd_q <= uf_mem[{u_q, kr}];
		if_rd_q <= if_mem[{i_q, kr}];
		if (st_q == ST_IDLE && in_valid && !ov_q) begin
			unique case (operation)
				OP_LOAD_UF: uf_mem[{user_index, element_index}] <= load_value;
				OP_LOAD_IF: if_mem[{item_index, element_index}] <= load_value;
				OP_LOAD_UB: ub_mem[user_index] <= load_value;
				OP_LOAD_IB: ib_mem[item_index] <= load_value;
				default: ;
			endcase
		end
		if (st_q == ST_U_B) uf_mem[{u_q, kk}] <= unew_calc(x_q, mp);
		if (st_q == ST_I_B) if_mem[{i_q, kk}] <= unew_calc(x_q, mp);
		if (st_q == ST_UB_B) ub_mem[u_q] <= unew_calc(x_q, mp);
		if (st_q == ST_IB_B) ib_mem[i_q] <= unew_calc(x_q, mp);
	end

	always_ff @(posedge clk) begin
		prod_q <= mp;
		unique case (st_q)
			ST_IDLE: if (in_valid && !ov_q) begin
				op_q <= operation;
				u_q <= user_index;
				i_q <= item_index;
				r_q <= rating;
				k_q <= '0;
				n_q <= (dim_q > 8'(MaxDim)) ? 8'(MaxDim) : dim_q;
			end
			ST_BRD: acc_q <= 56'(signed'({1'b0, mean_q})) + 56'(ub_rd_q) + 56'(ib_rd_q);
			ST_DOT: k_q <= k_q + 1'b1;
			ST_DOT_ACC: acc_q <= accsum;
			ST_FIN: begin
				pred_q <= clampv[18:0];
				err_q <= 32'(signed'({1'b0, r_q, 16'd0})) - 32'(clampv);
				errout_q <= (op_q == OP_TRAIN)
					? 32'(signed'({1'b0, r_q, 16'd0})) - 32'(clampv) : 32'sd0;
			end
			ST_OUT: k_q <= '0;
			ST_UB_A: x_q <= ub_rd_q;
			ST_IB_A: x_q <= ib_rd_q;
			ST_FRD: begin x_q <= uf_rd_q; qold_q <= if_rd_q; end
			ST_U_B: begin unew_q <= unew_calc(x_q, mp); x_q <= qold_q; end
			ST_I_B: k_q <= k_q + 1'b1;
			default: ;
		endcase
		// t = g - mul(beta, x), g is err for biases or last product
		if (st_q == ST_UB_A || st_q == ST_IB_A)
			t_q <= sat32({{18{err_q[31]}}, err_q} - {{18{mulsat[31]}}, mulsat});
		if (st_q == ST_FRD || st_q == ST_I_G) g_q <= mulsat;
		if (st_q == ST_U_A || st_q == ST_I_A)
			t_q <= sat32({{18{g_q[31]}}, g_q} - {{18{mulsat[31]}}, mulsat});
	end
endmodule

// ----- dv/tb_biased_matrix_factorization_sgd.sv -----
// Testbench for biased_matrix_factorization_sgd: directed and random load/train/predict beats
// with random idling on both sides, checked against a Q16.16 scoreboard model.
// Depends on bmf_pkg and the block's RTL only.
module tb_biased_matrix_factorization_sgd;
	import bmf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [18:0] prediction;
		logic signed [31:0] error;
	} rating_out_t;

	class mf_scoreboard;
		int unsigned mean_q, step_q, decay_q, dim_q;
		int user_bias[NumUsers];
		int item_bias[NumItems];
		int user_fac[NumUsers*MaxDim];
		int item_fac[NumItems*MaxDim];
		rating_out_t expected_q[$];
		int mismatches;

		function new();
			mean_q = 229376;
			step_q = 852;
			decay_q = 66;
			dim_q = 100;
			mismatches = 0;
		endfunction

		function void set_reg(logic [1:0] idx, int unsigned val);
			case (idx)
				REG_MEAN: mean_q = val & 32'h7ffff;
				REG_LRATE: step_q = val & 32'h1ffff;
				REG_REG: decay_q = val & 32'h1ffff;
				REG_DIM: dim_q = val & 32'hff;
				default: ;
			endcase
		endfunction

		function int active_dim();
			return (dim_q > MaxDim) ? MaxDim : dim_q;
		endfunction

		function longint mul_rnd(int a, int b);
			longint p;
			p = longint'(a) * longint'(b) + 64'sd32768;
			return p >>> 16;
		endfunction

		function int clip32(longint x);
			if (x > 64'sd2147483647) return 32'sh7fffffff;
			if (x < -64'sd2147483648) return 32'sh80000000;
			return int'(x);
		endfunction

		function int descend(int x, int g);
			int t;
			t = clip32(longint'(g) - longint'(clip32(mul_rnd(int'(decay_q), x))));
			return clip32(longint'(x) + longint'(clip32(mul_rnd(int'(step_q), t))));
		endfunction

		function int score(int u, int i);
			longint acc;
			acc = longint'(mean_q) + user_bias[u] + item_bias[i];
			for (int k = 0; k < active_dim(); k++)
				acc += mul_rnd(user_fac[u*MaxDim+k], item_fac[i*MaxDim+k]);
			if (acc < 65536) acc = 65536;
			if (acc > 327680) acc = 327680;
			return int'(acc);
		endfunction

		function void note_beat(logic [2:0] op, int u, int i, int e, int lv, int r);
			rating_out_t res;
			int p, err, g;
			case (op)
				OP_LOAD_UF: user_fac[u*MaxDim+e] = lv;
				OP_LOAD_IF: item_fac[i*MaxDim+e] = lv;
				OP_LOAD_UB: user_bias[u] = lv;
				OP_LOAD_IB: item_bias[i] = lv;
				OP_PREDICT: begin
					p = score(u, i);
					res.prediction = p[18:0];
					res.error = 0;
					expected_q.push_back(res);
				end
				OP_TRAIN: begin
					p = score(u, i);
					err = int'(longint'(r) * 65536 - p);
					res.prediction = p[18:0];
					res.error = err;
					expected_q.push_back(res);
					user_bias[u] = descend(user_bias[u], err);
					item_bias[i] = descend(item_bias[i], err);
					for (int k = 0; k < active_dim(); k++) begin
						g = clip32(mul_rnd(err, item_fac[i*MaxDim+k]));
						user_fac[u*MaxDim+k] = descend(user_fac[u*MaxDim+k], g);
						g = clip32(mul_rnd(err, user_fac[u*MaxDim+k]));
						item_fac[i*MaxDim+k] = descend(item_fac[i*MaxDim+k], g);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_beat(logic [18:0] pred, logic signed [31:0] err);
			rating_out_t exp_r;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: prediction %0d error %0d", pred, err);
				return;
			end
			exp_r = expected_q.pop_front();
			if (pred !== exp_r.prediction || err !== exp_r.error) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: prediction exp %0d got %0d, error exp %0d got %0d",
						exp_r.prediction, pred, exp_r.error, err);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [2:0] operation, rating;
	logic [9:0] user_index;
	logic [10:0] item_index;
	logic [6:0] element_index;
	logic signed [31:0] load_value;
	logic [18:0] prediction;
	logic signed [31:0] error;

	mf_scoreboard sb;
	bit ub_set[NumUsers];
	bit ib_set[NumItems];
	bit uf_set[NumUsers*MaxDim];
	bit if_set[NumItems*MaxDim];
	bit quiet, hold_out;
	int stall_left;

	biased_matrix_factorization_sgd dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("simulation failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic int pick_value();
		if ($urandom_range(0, 19) == 0) return int'($urandom());
		return int'($urandom_range(0, 32767)) - 16384;
	endfunction

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_beat(prediction, error);

	initial begin
		out_stall = 0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_stall <= 1;
				repeat (3000) @(posedge clk);
				hold_out = 0;
			end else if (stall_left > 0) begin
				out_stall <= 1;
				stall_left--;
			end else begin
				out_stall <= 0;
				stall_left = pick_gap();
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, int unsigned val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		sb.set_reg(idx, val);
	endtask

	task automatic send_beat(logic [2:0] op, int u, int i, int e, int lv, int r);
		int gap;
		int um, im, em, rm;
		um = u & (NumUsers - 1);
		im = i & (NumItems - 1);
		em = e & (MaxDim - 1);
		rm = r & 7;
		in_valid <= 1;
		operation <= op;
		user_index <= UW'(um);
		item_index <= IW'(im);
		element_index <= KW'(em);
		load_value <= lv;
		rating <= 3'(rm);
		do @(posedge clk); while (in_stall);
		sb.note_beat(op, um, im, em, lv, rm);
		case (op)
			OP_LOAD_UF: uf_set[um*MaxDim+em] = 1;
			OP_LOAD_IF: if_set[im*MaxDim+em] = 1;
			OP_LOAD_UB: ub_set[um] = 1;
			OP_LOAD_IB: ib_set[im] = 1;
			default: ;
		endcase
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// load whatever a train or predict on this pair would read
	task automatic prep_pair(int u, int i);
		if (!ub_set[u]) send_beat(OP_LOAD_UB, u, 0, 0, pick_value(), 0);
		if (!ib_set[i]) send_beat(OP_LOAD_IB, 0, i, 0, pick_value(), 0);
		for (int k = 0; k < sb.active_dim(); k++) begin
			if (!uf_set[u*MaxDim+k]) send_beat(OP_LOAD_UF, u, 0, k, pick_value(), 0);
			if (!if_set[i*MaxDim+k]) send_beat(OP_LOAD_IF, 0, i, k, pick_value(), 0);
		end
	endtask

	task automatic use_pair(logic [2:0] op, int u, int i, int r);
		prep_pair(u, i);
		send_beat(op, u, i, $urandom_range(0, 127), int'($urandom()), r);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	task automatic set_regs(int unsigned m, int unsigned lr, int unsigned rg, int unsigned d);
		write_reg(REG_MEAN, m);
		write_reg(REG_LRATE, lr);
		write_reg(REG_REG, rg);
		write_reg(REG_DIM, d);
	endtask

	task automatic run_phase(int n, int pool, bit press);
		int users[4], items[4];
		int r, u, i;
		for (int p = 0; p < 4; p++) begin
			users[p] = $urandom_range(0, NumUsers - 1);
			items[p] = $urandom_range(0, NumItems - 1);
		end
		for (int t = 0; t < n; t++) begin
			if (press && t == 10) hold_out = 1;
			r = $urandom_range(0, 99);
			u = users[$urandom_range(0, pool - 1)];
			i = items[$urandom_range(0, pool - 1)];
			if (r < 70)
				use_pair(r < 40 ? OP_TRAIN : OP_PREDICT, u, i,
					$urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 5));
			else if (r < 90)
				send_beat($urandom_range(0, 3), $urandom_range(0, NumUsers - 1),
					$urandom_range(0, NumItems - 1), $urandom_range(0, 127), pick_value(), 0);
			else if (r < 95)
				send_beat($urandom_range(6, 7), $urandom(), $urandom(), $urandom(),
					int'($urandom()), $urandom());
			else
				send_beat($urandom_range(0, 3), u, i, $urandom_range(0, sb.active_dim()),
					pick_value(), 0);
		end
		drain();
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		in_valid = 0;
		operation = 0;
		user_index = 0;
		item_index = 0;
		element_index = 0;
		load_value = 0;
		rating = 0;
		quiet = 0;
		hold_out = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		set_regs(229376, 852, 66, 4);
		send_beat(OP_LOAD_UB, 0, 0, 0, 32'sh7fffffff, 0);
		send_beat(OP_LOAD_IB, 0, 0, 0, 32'sh7fffffff, 0);
		send_beat(OP_LOAD_UF, 0, 0, 0, 32'sh80000000, 0);
		send_beat(OP_LOAD_UF, 0, 0, 1, 32'sh7fffffff, 0);
		send_beat(OP_LOAD_UF, 0, 0, 2, 32'sh80000000, 0);
		send_beat(OP_LOAD_UF, 0, 0, 3, 1, 0);
		send_beat(OP_LOAD_IF, 0, 0, 0, 32'sh80000000, 0);
		send_beat(OP_LOAD_IF, 0, 0, 1, 32'sh7fffffff, 0);
		send_beat(OP_LOAD_IF, 0, 0, 2, 32'sh7fffffff, 0);
		send_beat(OP_LOAD_IF, 0, 0, 3, -1, 0);
		use_pair(OP_PREDICT, 0, 0, 3);
		use_pair(OP_TRAIN, 0, 0, 0);
		use_pair(OP_TRAIN, 0, 0, 7);
		send_beat(OP_LOAD_UB, 1023, 0, 0, 32'sh80000000, 0);
		send_beat(OP_LOAD_IB, 0, 2047, 0, 32'sh80000000, 0);
		use_pair(OP_PREDICT, 1023, 2047, 1);
		use_pair(OP_TRAIN, 1023, 2047, 1);
		send_beat(3'd6, 1023, 2047, 127, -1, 7);
		send_beat(3'd7, 0, 0, 0, 0, 0);
		use_pair(OP_TRAIN, 5, 9, 5);
		use_pair(OP_TRAIN, 5, 9, 6);
		use_pair(OP_PREDICT, 5, 9, 0);
		drain();

		set_regs(65536, 0, 0, 1);
		run_phase(60, 4, 1);
		set_regs(327680, 65536, 65536, 0);
		run_phase(50, 4, 0);
		set_regs(229376, 852, 66, 8);
		run_phase(100, 4, 0);
		set_regs($urandom_range(65536, 327680), $urandom_range(0, 4096),
			$urandom_range(0, 4096), 255);
		run_phase(8, 1, 0);
		for (int ph = 0; ph < 4; ph++) begin
			quiet = (ph == 1);
			set_regs($urandom_range(65536, 327680), $urandom_range(0, 65536),
				$urandom_range(0, 65536), $urandom_range(1, 12));
			run_phase(70, $urandom_range(1, 4), 0);
		end

		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ----- sim.f -----
hdl/bmf_pkg.sv
hdl/biased_matrix_factorization_sgd.sv
dv/tb_biased_matrix_factorization_sgd.sv
